// ===== hw/rtl/axis_rect_ray_hit_macros.svh =====
// Assertion macros for the ray/rectangle hit block.
// Used by the port checker; depends on nothing else.
`ifndef AXIS_RECT_RAY_HIT_MACROS_SVH
`define AXIS_RECT_RAY_HIT_MACROS_SVH

// Clocked implication or condition that must hold outside reset.
`define RAH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define RAH_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/rah_pkg.sv =====
// Types, widths and helpers shared by the ray/rectangle hit block.
// No dependencies.
package rah_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned TexW     = FracBits + 1;
  // Dividend of the t quotient: magnitude of (offset - origin) shifted up.
  localparam int unsigned TDivW    = CoordW + 1 + FracBits;
  localparam int unsigned NumRegs  = 7;

  typedef enum logic [2:0] {
    RegPlaneAxis   = 3'd0,
    RegPlaneOffset = 3'd1,
    RegALow        = 3'd2,
    RegAHigh       = 3'd3,
    RegBLow        = 3'd4,
    RegBHigh       = 3'd5,
    RegMaterial    = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] t_lower;
    logic signed [CoordW-1:0] t_upper;
  } ray_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] hit_t;
    logic [TexW-1:0]          tex_u;
    logic [TexW-1:0]          tex_v;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic [1:0]               normal_axis;
    logic [15:0]              hit_material;
  } result_t;

  // Payload carried along the t divider.
  typedef struct packed {
    ray_t ray;
    logic neg;
    logic ok;
  } tpay_t;

  // After t is known.
  typedef struct packed {
    ray_t                     ray;
    logic signed [CoordW-1:0] t;
    logic                     ok;
  } spay_t;

  // After the three products.
  typedef struct packed {
    ray_t                       ray;
    logic signed [CoordW-1:0]   t;
    logic signed [2*CoordW-1:0] prod_x;
    logic signed [2*CoordW-1:0] prod_y;
    logic signed [2*CoordW-1:0] prod_z;
    logic                       ok;
  } mpay_t;

  // After the hit point.
  typedef struct packed {
    logic signed [CoordW-1:0] t;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic                     ok;
  } ppay_t;

  // Payload carried along the texture dividers.
  typedef struct packed {
    logic signed [CoordW-1:0] t;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic                     ok;
    logic                     zero_u;
    logic                     zero_v;
  } xpay_t;

  // Product shifted down by the fraction bits, rounded toward zero, plus origin;
  // the sum is returned at double width so the caller can check its range.
  function automatic logic [2*CoordW-1:0] add_scaled(logic signed [2*CoordW-1:0] prod,
                                                     logic signed [CoordW-1:0] org);
    logic signed [2*CoordW-1:0] adj;
    logic signed [2*CoordW-1:0] shv;
    adj = prod + (prod[2*CoordW-1] ? (2*CoordW)'((64'd1 << FracBits) - 64'd1)
                                   : (2*CoordW)'(0));
    shv = adj >>> FracBits;
    return shv + (2*CoordW)'(org);
  endfunction

  function automatic logic fits_coord(logic [2*CoordW-1:0] v);
    return (&v[2*CoordW-1:CoordW-1]) | ~(|v[2*CoordW-1:CoordW-1]);
  endfunction

endpackage

// ===== hw/rtl/rah_pipe_reg.sv =====
// One valid/ready pipeline register with a flat payload.
// No dependencies.
module rah_pipe_reg #(
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [PW-1:0] data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [PW-1:0] data_o
);

  logic          valid_q;
  logic [PW-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== hw/rtl/rah_div_cell.sv =====
// One restoring-division step per lane, registered, with a payload that rides along.
// No dependencies; a row of these forms a pipelined divider.
module rah_div_cell #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 8,
  parameter int unsigned DW    = 8,
  parameter int unsigned PW    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [LANES-1:0][DW-1:0]   rem_i,
  input  logic [LANES-1:0][NW-1:0]   dq_i,
  input  logic [LANES-1:0][DW-1:0]   div_i,
  input  logic [PW-1:0]              pay_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [LANES-1:0][DW-1:0]   rem_o,
  output logic [LANES-1:0][NW-1:0]   dq_o,
  output logic [LANES-1:0][DW-1:0]   div_o,
  output logic [PW-1:0]              pay_o
);

  logic                     valid_q;
  logic [LANES-1:0][DW-1:0] rem_d, rem_q;
  logic [LANES-1:0][NW-1:0] dq_d, dq_q;
  logic [LANES-1:0][DW-1:0] div_q;
  logic [PW-1:0]            pay_q;
  logic [LANES-1:0][DW:0]   sh, sub;
  logic [LANES-1:0]         ge;

  // The remainder stays below the divisor, so one compare and subtract per step.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign sh[l]    = {rem_i[l], dq_i[l][NW-1]};
    assign sub[l]   = sh[l] - {1'b0, div_i[l]};
    assign ge[l]    = sh[l] >= {1'b0, div_i[l]};
    assign rem_d[l] = ge[l] ? sub[l][DW-1:0] : sh[l][DW-1:0];
    assign dq_d[l]  = {dq_i[l][NW-2:0], ge[l]};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dq_o    = dq_q;
  assign div_o   = div_q;
  assign pay_o   = pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
      div_q <= div_i;
      pay_q <= pay_i;
    end
  end

endmodule

// ===== hw/rtl/axis_rect_ray_hit.sv =====
// Top level of the ray/axis-aligned rectangle hit test.
// Uses rah_pkg, rah_div_cell and rah_pipe_reg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------
//   in      | input     | in_valid_i/in_ready_o | in_data_i (ray)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (result)
//   cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One ray is taken per cycle unless a stall has filled the pipe. Each ray passes
// through 49 cells of the t divider, three arithmetic stages, 17 cells of the
// texture dividers and the output register. Reset clears the registers to
// their defaults and empties the pipe. A stall at the output backs up one
// stage at a time, so the input keeps accepting until every stage is full.
module axis_rect_ray_hit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rah_pkg::ray_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rah_pkg::result_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int unsigned CW  = rah_pkg::CoordW;
  localparam int unsigned FB  = rah_pkg::FracBits;
  localparam int unsigned TN  = rah_pkg::TDivW;
  localparam int unsigned XN  = rah_pkg::TexW;
  localparam int unsigned TPW = $bits(rah_pkg::tpay_t);
  localparam int unsigned XPW = $bits(rah_pkg::xpay_t);

  // Configuration registers.
  logic [1:0]           axis_q;
  logic signed [CW-1:0] offset_q, alo_q, ahi_q, blo_q, bhi_q;
  logic [15:0]          mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= rah_pkg::AxisZ;
      offset_q <= '0;
      alo_q    <= '0;
      ahi_q    <= CW'(64'd1 << FB);
      blo_q    <= '0;
      bhi_q    <= CW'(64'd1 << FB);
      mat_q    <= '0;
    end else if (cfg_we_i) begin
      case (rah_pkg::reg_idx_e'(cfg_idx_i))
        rah_pkg::RegPlaneAxis:   axis_q   <= cfg_data_i[1:0];
        rah_pkg::RegPlaneOffset: offset_q <= cfg_data_i[CW-1:0];
        rah_pkg::RegALow:        alo_q    <= cfg_data_i[CW-1:0];
        rah_pkg::RegAHigh:       ahi_q    <= cfg_data_i[CW-1:0];
        rah_pkg::RegBLow:        blo_q    <= cfg_data_i[CW-1:0];
        rah_pkg::RegBHigh:       bhi_q    <= cfg_data_i[CW-1:0];
        rah_pkg::RegMaterial:    mat_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Operand preparation for the t divider.
  logic signed [CW-1:0] o_n, d_n;
  logic                 axis_ok;
  logic [CW:0]          num, mag_num;
  logic [CW-1:0]        mag_dir;
  rah_pkg::tpay_t       tpay_in;

  always_comb begin
    axis_ok = 1'b1;
    case (axis_q)
      rah_pkg::AxisX: begin
        o_n = in_data_i.origin_x;
        d_n = in_data_i.dir_x;
      end
      rah_pkg::AxisY: begin
        o_n = in_data_i.origin_y;
        d_n = in_data_i.dir_y;
      end
      rah_pkg::AxisZ: begin
        o_n = in_data_i.origin_z;
        d_n = in_data_i.dir_z;
      end
      default: begin
        o_n     = '0;
        d_n     = '0;
        axis_ok = 1'b0;
      end
    endcase
    num     = {offset_q[CW-1], offset_q} - {o_n[CW-1], o_n};
    mag_num = num[CW] ? ((CW+1)'(0) - num) : num;
    mag_dir = d_n[CW-1] ? (CW'(0) - d_n) : d_n;
    tpay_in.ray = in_data_i;
    tpay_in.neg = num[CW] ^ d_n[CW-1];
    tpay_in.ok  = axis_ok && (d_n != '0);
  end

  // t divider: one quotient bit per cell.
  logic                 t_valid [TN+1];
  logic                 t_ready [TN+1];
  logic [0:0][CW-1:0]   t_rem   [TN+1];
  logic [0:0][TN-1:0]   t_dq    [TN+1];
  logic [0:0][CW-1:0]   t_div   [TN+1];
  logic [TPW-1:0]       t_pay   [TN+1];

  assign t_valid[0] = in_valid_i;
  assign in_ready_o = t_ready[0];
  assign t_rem[0]   = '0;
  assign t_dq[0]    = {mag_num, FB'(0)};
  assign t_div[0]   = mag_dir;
  assign t_pay[0]   = tpay_in;

  for (genvar k = 0; k < TN; k++) begin : g_tcell
    rah_div_cell #(.LANES(1), .NW(TN), .DW(CW), .PW(TPW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(t_valid[k]),   .ready_o(t_ready[k]),
      .rem_i(t_rem[k]),       .dq_i(t_dq[k]),
      .div_i(t_div[k]),       .pay_i(t_pay[k]),
      .valid_o(t_valid[k+1]), .ready_i(t_ready[k+1]),
      .rem_o(t_rem[k+1]),     .dq_o(t_dq[k+1]),
      .div_o(t_div[k+1]),     .pay_o(t_pay[k+1])
    );
  end

  // Signed t, range and interval checks.
  rah_pkg::tpay_t       t_end;
  logic [TN-1:0]        quo;
  logic                 q_fits;
  logic signed [CW-1:0] t_val;
  rah_pkg::spay_t       s_d, s_q;
  logic                 s_valid, s_ready;

  always_comb begin
    t_end  = rah_pkg::tpay_t'(t_pay[TN]);
    quo    = t_dq[TN][0];
    // A negative t may reach the most negative code; a positive one may not.
    q_fits = !(|quo[TN-1:CW]) &&
             (t_end.neg ? (!quo[CW-1] || (quo[CW-2:0] == '0)) : !quo[CW-1]);
    t_val  = t_end.neg ? (CW'(0) - quo[CW-1:0]) : quo[CW-1:0];
    s_d.ray = t_end.ray;
    s_d.t   = t_val;
    s_d.ok  = t_end.ok && q_fits && (t_val >= t_end.ray.t_lower) &&
              (t_val <= t_end.ray.t_upper);
  end

  rah_pipe_reg #(.PW($bits(rah_pkg::spay_t))) u_s_reg (
    .clk_i, .rst_ni,
    .valid_i(t_valid[TN]), .ready_o(t_ready[TN]), .data_i(s_d),
    .valid_o(s_valid),     .ready_i(s_ready),     .data_o(s_q)
  );

  // Products t * dir.
  rah_pkg::mpay_t m_d, m_q;
  logic           m_valid, m_ready;

  always_comb begin
    m_d.ray    = s_q.ray;
    m_d.t      = s_q.t;
    m_d.prod_x = s_q.t * s_q.ray.dir_x;
    m_d.prod_y = s_q.t * s_q.ray.dir_y;
    m_d.prod_z = s_q.t * s_q.ray.dir_z;
    m_d.ok     = s_q.ok;
  end

  rah_pipe_reg #(.PW($bits(rah_pkg::mpay_t))) u_m_reg (
    .clk_i, .rst_ni,
    .valid_i(s_valid), .ready_o(s_ready), .data_i(m_d),
    .valid_o(m_valid), .ready_i(m_ready), .data_o(m_q)
  );

  // Hit point.
  logic [2*CW-1:0] sum_x, sum_y, sum_z;
  rah_pkg::ppay_t  p_d, p_q;
  logic            p_valid, p_ready;

  always_comb begin
    sum_x  = rah_pkg::add_scaled(m_q.prod_x, m_q.ray.origin_x);
    sum_y  = rah_pkg::add_scaled(m_q.prod_y, m_q.ray.origin_y);
    sum_z  = rah_pkg::add_scaled(m_q.prod_z, m_q.ray.origin_z);
    p_d.t  = m_q.t;
    p_d.px = sum_x[CW-1:0];
    p_d.py = sum_y[CW-1:0];
    p_d.pz = sum_z[CW-1:0];
    p_d.ok = m_q.ok && rah_pkg::fits_coord(sum_x) && rah_pkg::fits_coord(sum_y) &&
             rah_pkg::fits_coord(sum_z);
  end

  rah_pipe_reg #(.PW($bits(rah_pkg::ppay_t))) u_p_reg (
    .clk_i, .rst_ni,
    .valid_i(m_valid), .ready_o(m_ready), .data_i(p_d),
    .valid_o(p_valid), .ready_i(p_ready), .data_o(p_q)
  );

  // Bounds test and texture divider operands.
  logic signed [CW-1:0] pa, pb;
  logic [CW:0]          du, dv, ru, rv;
  rah_pkg::xpay_t       xpay_in;

  always_comb begin
    case (axis_q)
      rah_pkg::AxisX: begin
        pa = p_q.py;
        pb = p_q.pz;
      end
      rah_pkg::AxisY: begin
        pa = p_q.px;
        pb = p_q.pz;
      end
      default: begin
        pa = p_q.px;
        pb = p_q.py;
      end
    endcase
    du = {pa[CW-1], pa} - {alo_q[CW-1], alo_q};
    dv = {pb[CW-1], pb} - {blo_q[CW-1], blo_q};
    ru = {ahi_q[CW-1], ahi_q} - {alo_q[CW-1], alo_q};
    rv = {bhi_q[CW-1], bhi_q} - {blo_q[CW-1], blo_q};
    xpay_in.t      = p_q.t;
    xpay_in.px     = p_q.px;
    xpay_in.py     = p_q.py;
    xpay_in.pz     = p_q.pz;
    xpay_in.ok     = p_q.ok && (pa >= alo_q) && (pa <= ahi_q) &&
                     (pb >= blo_q) && (pb <= bhi_q);
    xpay_in.zero_u = (ahi_q == alo_q);
    xpay_in.zero_v = (bhi_q == blo_q);
  end

  // Texture dividers, u and v side by side. The offset never exceeds the
  // width, so the first bit is taken by preloading half of it.
  logic               x_valid [XN+1];
  logic               x_ready [XN+1];
  logic [1:0][CW-1:0] x_rem   [XN+1];
  logic [1:0][XN-1:0] x_dq    [XN+1];
  logic [1:0][CW-1:0] x_div   [XN+1];
  logic [XPW-1:0]     x_pay   [XN+1];

  assign x_valid[0] = p_valid;
  assign p_ready    = x_ready[0];
  assign x_rem[0]   = {du[CW:1], dv[CW:1]};
  assign x_dq[0]    = {{du[0], FB'(0)}, {dv[0], FB'(0)}};
  assign x_div[0]   = {ru[CW-1:0], rv[CW-1:0]};
  assign x_pay[0]   = xpay_in;

  for (genvar k = 0; k < XN; k++) begin : g_xcell
    rah_div_cell #(.LANES(2), .NW(XN), .DW(CW), .PW(XPW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(x_valid[k]),   .ready_o(x_ready[k]),
      .rem_i(x_rem[k]),       .dq_i(x_dq[k]),
      .div_i(x_div[k]),       .pay_i(x_pay[k]),
      .valid_o(x_valid[k+1]), .ready_i(x_ready[k+1]),
      .rem_o(x_rem[k+1]),     .dq_o(x_dq[k+1]),
      .div_o(x_div[k+1]),     .pay_o(x_pay[k+1])
    );
  end

  // Result assembly; a miss gives all zeros.
  rah_pkg::xpay_t   x_end;
  rah_pkg::result_t res_d;

  always_comb begin
    x_end = rah_pkg::xpay_t'(x_pay[XN]);
    res_d = '0;
    if (x_end.ok) begin
      res_d.hit          = 1'b1;
      res_d.hit_t        = x_end.t;
      res_d.tex_u        = x_end.zero_u ? '0 : x_dq[XN][1];
      res_d.tex_v        = x_end.zero_v ? '0 : x_dq[XN][0];
      res_d.point_x      = x_end.px;
      res_d.point_y      = x_end.py;
      res_d.point_z      = x_end.pz;
      res_d.normal_axis  = axis_q;
      res_d.hit_material = mat_q;
    end
  end

  rah_pipe_reg #(.PW($bits(rah_pkg::result_t))) u_out_reg (
    .clk_i, .rst_ni,
    .valid_i(x_valid[XN]), .ready_o(x_ready[XN]), .data_i(res_d),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .data_o(out_data_o)
  );

endmodule

// ===== hw/rtl/rah_checker.sv =====
// Port-level checks for the ray/rectangle hit block, bound to the top level.
// Uses rah_pkg and axis_rect_ray_hit_macros.svh.
`include "axis_rect_ray_hit_macros.svh"

module rah_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input rah_pkg::result_t out_data_o
);

  localparam logic [rah_pkg::TexW-1:0] TexOne = rah_pkg::TexW'(1 << rah_pkg::FracBits);

  logic out_wait, miss_seen, hit_bad;

  assign out_wait  = out_valid_o && !out_ready_i;
  assign miss_seen = out_valid_o && !out_data_o.hit;
  assign hit_bad   = out_valid_o && out_data_o.hit &&
                     ((out_data_o.tex_u > TexOne) || (out_data_o.tex_v > TexOne) ||
                      (out_data_o.normal_axis > rah_pkg::AxisZ));

  // A result that waits must stay offered.
  `RAH_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> out_valid_o, "out valid dropped")

  // A waiting result must not change.
  `RAH_ASSERT(a_out_stable, clk_i, rst_ni, out_wait |=> $stable(out_data_o), "out payload changed")

  // A miss carries nothing but zeros.
  `RAH_ASSERT(a_miss_zero, clk_i, rst_ni, miss_seen |-> out_data_o == '0, "miss not zero")

  // A hit has normalized texture coordinates and a real axis.
  `RAH_NEVER(a_hit_range, clk_i, rst_ni, hit_bad, "hit fields out of range")

endmodule

bind axis_rect_ray_hit rah_checker u_rah_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for axis_rect_ray_hit: rays against a configured rectangle.
// Predicts each result in SystemVerilog and compares it with the whole output result.
// Depends on rah_pkg and the axis_rect_ray_hit RTL.
module tb;

  localparam int unsigned LatencyCycles = 70;
  localparam longint      LimitCycles   = 600000;
  localparam longint      CoordMax      = 64'sd2147483647;
  localparam longint      CoordMin      = -64'sd2147483648;
  // Axis code with no plane and a register index past the last register.
  localparam logic [1:0]  AxisUnused    = 2'd3;
  localparam logic [2:0]  RegNone       = 3'd7;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  rah_pkg::ray_t    in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  rah_pkg::result_t out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [31:0]      cfg_data_i = '0;

  axis_rect_ray_hit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [1:0]         sh_axis;
  logic signed [31:0] sh_offset, sh_alo, sh_ahi, sh_blo, sh_bhi;
  logic [15:0]        sh_material;

  rah_pkg::ray_t    ray_queue[$];
  rah_pkg::result_t expected_hits[$];
  int      mismatch_count = 0;
  longint  cycle_count = 0;
  int      send_gap = 0;
  int      recv_gap = 0;

  // Exact (n << FracBits) / d on magnitudes.
  function automatic logic [127:0] frac_quotient(logic [63:0] n, logic [63:0] d);
    logic [127:0] wide;
    wide = {64'd0, n} << rah_pkg::FracBits;
    return wide / {64'd0, d};
  endfunction

  function automatic logic [rah_pkg::TexW-1:0] tex_coord(longint c, longint lo, longint hi);
    longint diff, span;
    logic [127:0] q;
    if (hi == lo) return '0;
    diff = c - lo;
    span = hi - lo;
    if (diff < 0) diff = -diff;
    if (span < 0) span = -span;
    q = frac_quotient(diff, span);
    return q[rah_pkg::TexW-1:0];
  endfunction

  function automatic rah_pkg::result_t predict_hit(rah_pkg::ray_t r);
    rah_pkg::result_t res;
    longint o[3], d[3], p[3];
    longint tval, num, tl, tu, prod;
    logic [127:0] q, mag_q;
    logic signed [127:0] wide_prod;
    int ia, ib, ax;
    res = '0;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
    tl = r.t_lower;
    tu = r.t_upper;
    if (sh_axis > rah_pkg::AxisZ) return res;
    ax = sh_axis;
    ia = (ax == rah_pkg::AxisX) ? 1 : 0;
    ib = (ax == rah_pkg::AxisZ) ? 1 : 2;
    if (d[ax] == 0) return res;
    num = longint'(sh_offset) - o[ax];
    q = frac_quotient(num < 0 ? -num : num, d[ax] < 0 ? -d[ax] : d[ax]);
    if (q > 128'd2147483648) return res;
    tval = longint'(q[63:0]);
    if ((num < 0) != (d[ax] < 0)) tval = -tval;
    if (tval > CoordMax || tval < CoordMin) return res;
    if (tval < tl || tval > tu) return res;
    for (int i = 0; i < 3; i++) begin
      wide_prod = 128'(tval) * 128'(d[i]);
      mag_q = wide_prod < 0 ? -wide_prod : wide_prod;
      mag_q = mag_q >> rah_pkg::FracBits;
      prod = longint'(mag_q[63:0]);
      if (wide_prod < 0) prod = -prod;
      p[i] = o[i] + prod;
      if (p[i] > CoordMax || p[i] < CoordMin) return res;
    end
    if (p[ia] < sh_alo || p[ia] > sh_ahi || p[ib] < sh_blo || p[ib] > sh_bhi)
      return res;
    res.hit          = 1'b1;
    res.hit_t        = tval[31:0];
    res.tex_u        = tex_coord(p[ia], sh_alo, sh_ahi);
    res.tex_v        = tex_coord(p[ib], sh_blo, sh_bhi);
    res.point_x      = p[0][31:0];
    res.point_y      = p[1][31:0];
    res.point_z      = p[2][31:0];
    res.normal_axis  = sh_axis;
    res.hit_material = sh_material;
    return res;
  endfunction

  function automatic int random_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: keeps valid and payload steady until the transaction completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_hits.push_back(predict_hit(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (ray_queue.size() > 0) begin
          in_data_i  <= ray_queue.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= random_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and output stall generator.
  always @(posedge clk_i) begin
    rah_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result %p", out_data_o);
        end else begin
          want = expected_hits.pop_front();
          if (want !== out_data_o) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected %p got %p", want, out_data_o);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= random_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("axis_rect_ray_hit test failed");
      $finish;
    end
  end

  task automatic write_reg(rah_pkg::reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rah_pkg::RegPlaneAxis:   sh_axis     = value[1:0];
      rah_pkg::RegPlaneOffset: sh_offset   = value;
      rah_pkg::RegALow:        sh_alo      = value;
      rah_pkg::RegAHigh:       sh_ahi      = value;
      rah_pkg::RegBLow:        sh_blo      = value;
      rah_pkg::RegBHigh:       sh_bhi      = value;
      rah_pkg::RegMaterial:    sh_material = value[15:0];
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    while (ray_queue.size() > 0 || in_valid_i || expected_hits.size() > 0)
      @(posedge clk_i);
    repeat (LatencyCycles + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  // A ray aimed at the rectangle with random jitter, so many transactions hit.
  function automatic rah_pkg::ray_t aimed_ray();
    rah_pkg::ray_t r;
    logic signed [31:0] tgt[3], org[3], dir[3];
    int ax;
    ax = sh_axis > rah_pkg::AxisZ ? int'(rah_pkg::AxisZ) : int'(sh_axis);
    for (int i = 0; i < 3; i++) begin
      dir[i] = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      tgt[i] = 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
    end
    if (dir[ax] == 0) dir[ax] = 32'sd65536;
    tgt[ax] = sh_offset;
    for (int i = 0; i < 3; i++) org[i] = tgt[i] - dir[i];
    r.origin_x = org[0]; r.origin_y = org[1]; r.origin_z = org[2];
    r.dir_x = dir[0];    r.dir_y = dir[1];    r.dir_z = dir[2];
    r.t_lower = $urandom_range(0, 3) == 0 ? rand_coord() : 32'sh8000_0000;
    r.t_upper = $urandom_range(0, 3) == 0 ? rand_coord() : 32'sh7FFF_FFFF;
    return r;
  endfunction

  function automatic rah_pkg::ray_t noise_ray();
    rah_pkg::ray_t r;
    r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
    r.dir_x = rand_coord();    r.dir_y = rand_coord();    r.dir_z = rand_coord();
    if ($urandom_range(0, 3) == 0) r.dir_z = 0;
    r.t_lower = rand_coord();
    r.t_upper = rand_coord();
    return r;
  endfunction

  initial begin
    rah_pkg::ray_t r;
    sh_axis = rah_pkg::AxisZ; sh_offset = 0; sh_alo = 0; sh_ahi = 32'sd65536;
    sh_blo = 0; sh_bhi = 32'sd65536; sh_material = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rays against the reset rectangle.
    r = '0; r.dir_z = 32'sd65536; r.origin_x = 32'sd32768; r.origin_y = 32'sd32768;
    r.origin_z = -32'sd65536; r.t_lower = 32'sh8000_0000; r.t_upper = 32'sh7FFF_FFFF;
    ray_queue.push_back(r);
    r.origin_x = 0; r.origin_y = 32'sd65536;
    ray_queue.push_back(r);
    r.origin_x = 32'sd65537;
    ray_queue.push_back(r);
    r.origin_x = 0; r.dir_z = 0;
    ray_queue.push_back(r);
    r.dir_z = 32'sd1; r.origin_z = 32'sh8000_0000;
    ray_queue.push_back(r);
    r.dir_z = 32'sh8000_0000; r.origin_z = 32'sh7FFF_FFFF;
    ray_queue.push_back(r);
    r.dir_z = 32'sd65536; r.origin_z = -32'sd65536; r.t_lower = 32'sd65536;
    r.t_upper = 32'sd65536;
    ray_queue.push_back(r);
    r.t_lower = 32'sd65537;
    ray_queue.push_back(r);
    r.t_lower = 32'sd131072; r.t_upper = 0;
    ray_queue.push_back(r);
    r = '1;
    ray_queue.push_back(r);
    r.dir_x = 32'sh7FFF_FFFF; r.dir_z = 32'sd65536; r.t_lower = 32'sh8000_0000;
    r.t_upper = 32'sh7FFF_FFFF; r.origin_z = -32'sd65536; r.origin_x = 0; r.origin_y = 0;
    ray_queue.push_back(r);
    for (int i = 0; i < 8; i++) ray_queue.push_back(aimed_ray());
    // Hold off until every outstanding result has returned.
    drain_pipe();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(rah_pkg::RegPlaneAxis, rah_pkg::AxisX);
          write_reg(rah_pkg::RegPlaneOffset, 32'h0001_8000);
          write_reg(rah_pkg::RegALow, 32'hFFFF_0000);
          write_reg(rah_pkg::RegAHigh, 32'h0002_0000);
          write_reg(rah_pkg::RegBLow, 32'hFFFE_0000);
          write_reg(rah_pkg::RegBHigh, 32'h0001_0000);
          write_reg(rah_pkg::RegMaterial, 16'hFFFF);
        end
        1: begin
          write_reg(rah_pkg::RegPlaneAxis, rah_pkg::AxisY);
          write_reg(rah_pkg::RegPlaneOffset, 32'h8000_0000);
          write_reg(rah_pkg::RegALow, 32'h8000_0000);
          write_reg(rah_pkg::RegAHigh, 32'h7FFF_FFFF);
          write_reg(rah_pkg::RegBLow, 32'h8000_0000);
          write_reg(rah_pkg::RegBHigh, 32'h7FFF_FFFF);
          write_reg(rah_pkg::RegMaterial, 16'h5A5A);
        end
        2: begin
          write_reg(rah_pkg::RegPlaneOffset, 32'h7FFF_FFFF);
          write_reg(rah_pkg::RegMaterial, 16'hA5A5);
        end
        3: begin
          write_reg(rah_pkg::RegPlaneAxis, rah_pkg::AxisZ);
          write_reg(rah_pkg::RegPlaneOffset, 0);
          write_reg(rah_pkg::RegALow, 32'h0001_0000);
          write_reg(rah_pkg::RegAHigh, 32'h0001_0000);
          write_reg(rah_pkg::RegBLow, 32'h0002_0000);
          write_reg(rah_pkg::RegBHigh, 32'hFFFE_0000);
        end
        4: begin
          write_reg(rah_pkg::RegPlaneAxis, AxisUnused);
          write_reg(rah_pkg::RegBLow, 32'hFFFD_0000);
          write_reg(rah_pkg::RegBHigh, 32'h0003_0000);
        end
        5: begin
          write_reg(rah_pkg::RegPlaneAxis, rah_pkg::AxisX);
          write_reg(rah_pkg::RegALow, 32'hFFFD_0000);
          write_reg(rah_pkg::RegAHigh, 32'h0003_0000);
          write_reg(rah_pkg::RegMaterial, 0);
        end
        6: begin
          write_reg(rah_pkg::RegPlaneAxis, rah_pkg::AxisY);
          write_reg(rah_pkg::RegPlaneOffset, 32'hFFFF_0000);
          write_reg(rah_pkg::reg_idx_e'(RegNone), 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(rah_pkg::RegPlaneAxis, rah_pkg::AxisZ);
          write_reg(rah_pkg::RegPlaneOffset, 32'h0000_4000);
        end
      endcase
      for (int i = 0; i < 85; i++)
        ray_queue.push_back($urandom_range(0, 9) < 7 ? aimed_ray() : noise_ray());
      drain_pipe();
    end
    if (mismatch_count == 0) begin
      $display("axis_rect_ray_hit test passed");
    end else begin
      $display("axis_rect_ray_hit test failed");
    end
    $finish;
  end
endmodule
